>>> rtl/core/bcpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier point evaluator package
// Shared constants, register indexes, reset values, binomial table and the
// stage-enable groups passed between the pipeline modules.
// ----------------------------------------------------------------------------
package bcpe_pkg;

  // Default sizing of the evaluator
  localparam int MAX_POINTS_DEF      = 7;
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // Binomial table covers curves of up to seven points
  localparam int TABLE_SIZE = 7;
  localparam int BINOM_W    = 5;

  // Configuration register map
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_POINTS_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_ZERO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 3'd7;

  // Reset control points, Q7.8, sign-extended to the coordinate width
  localparam logic signed [15:0] PT_RST_X [TABLE_SIZE] = '{
    16'shF600, 16'shF600, 16'sh0A00, 16'sh0A00, 16'sh0A00, 16'sh0000, 16'sh0000
  };
  localparam logic signed [15:0] PT_RST_Y [TABLE_SIZE] = '{
    16'sh0000, 16'sh0A00, 16'sh0A00, 16'sh0000, 16'shF600, 16'sh0000, 16'sh0000
  };
  localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RST = 3'd7;

  localparam logic [BINOM_W-1:0] BINOM_TAB [TABLE_SIZE][TABLE_SIZE] = '{
    '{5'd1, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd1, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd2, 5'd1,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd3, 5'd3,  5'd1,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd4, 5'd6,  5'd4,  5'd1,  5'd0, 5'd0},
    '{5'd1, 5'd5, 5'd10, 5'd10, 5'd5,  5'd1, 5'd0},
    '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
  };

  // C(deg, k); zero outside the table
  function automatic logic [BINOM_W-1:0] binom_coef(input logic [2:0] deg,
                                                    input logic [2:0] k);
    logic [BINOM_W-1:0] c;
    c = '0;
    if (deg < 3'(TABLE_SIZE) && k < 3'(TABLE_SIZE)) begin
      c = BINOM_TAB[deg][k];
    end
    return c;
  endfunction

  // Stage enables of the weight unit
  typedef struct packed {
    logic prod;
    logic scale;
  } wgt_en_t;

  // Stage enables of the accumulate unit
  typedef struct packed {
    logic mul;
    logic sum;
    logic rnd;
  } acc_en_t;

endpackage
`default_nettype wire

>>> rtl/core/bezier_curve_point_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Evaluates a 2D Bezier curve at one parameter u per word, Bernstein form.
// ----------------------------------------------------------------------------
// Usage:
//   Configure control points (index 0..6, x in the low half, y in the high
//   half) and the point count (index 7) through cfg_we/cfg_index/cfg_data,
//   only while no word is in flight.
//   Present u (Q1.16, 65536 = 1.0, larger values clamp to 1.0) on the input
//   channel; a word is taken when in_valid is high and in_stall is low.
//   The result channel returns one word (curve_x, curve_y, Q7.8, saturated)
//   per input word, in order.
// Pipeline and throughput:
//   MAX_POINTS+4 register stages: input, MAX_POINTS-2 power stages, weight
//   product, binomial scale, point multiply, sum, round/saturate. out_valid
//   is the valid flag of the round/saturate stage.
//   One word per cycle sustained while the receiver does not stall; the
//   power ladder, one multiply per stage, sets the depth.
// Reset and stall:
//   Reset empties the pipeline and loads the default control points and a
//   count of seven. When the receiver stalls, each stage holds only while the
//   stage after it is full, so bubbles close up and in_stall rises only once
//   every stage holds a word.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval #(
  parameter int MAX_POINTS      = bcpe_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH     = bcpe_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = bcpe_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [2*COORD_WIDTH-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [PARAM_FRAC_BITS:0]         in_param_u,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COORD_WIDTH-1:0]    out_curve_x,
  output logic signed [COORD_WIDTH-1:0]    out_curve_y
);
  import bcpe_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = PARAM_FRAC_BITS;
  localparam int UW = F + 1;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int WW = UW + BINOM_W;
  localparam int NP = MAX_POINTS - 2;   // power stages
  localparam int NS = NP + 6;           // all register stages
  localparam logic [UW-1:0] ONE = {1'b1, {F{1'b0}}};

  // ---- configuration registers ----
  logic [2*CW-1:0]         point_r [MAX_POINTS];
  logic [NUM_POINTS_W-1:0] num_points_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        point_r[i] <= {CW'(PT_RST_Y[i]), CW'(PT_RST_X[i])};
      end
      num_points_r <= NUM_POINTS_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_POINTS) begin
        num_points_r <= cfg_data[NUM_POINTS_W-1:0];
      end
      // points beyond MAX_POINTS have no storage: drop those writes
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_POINT_ZERO + CFG_IDX_W'(i))) begin
          point_r[i] <= cfg_data;
        end
      end
    end
  end

  // Clamp the count to [2, MAX_POINTS]; degree is one less
  logic [NUM_POINTS_W-1:0] deg;
  always_comb begin
    logic [NUM_POINTS_W-1:0] cnt;
    cnt = num_points_r;
    if (cnt < NUM_POINTS_W'(2)) begin
      cnt = NUM_POINTS_W'(2);
    end
    if (cnt > NUM_POINTS_W'(MAX_POINTS)) begin
      cnt = NUM_POINTS_W'(MAX_POINTS);
    end
    deg = cnt - NUM_POINTS_W'(1);
  end

  logic signed [CW-1:0] pt_x [MAX_POINTS];
  logic signed [CW-1:0] pt_y [MAX_POINTS];
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      pt_x[i] = point_r[i][CW-1:0];
      pt_y[i] = point_r[i][2*CW-1:CW];
    end
  end

  // ---- valid chain and stage enables ----
  // A stage loads when it is empty or its word moves on this cycle.
  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

  // ---- input stage: clamp u, form 1-u ----
  logic [UW-1:0] u_r, v_r, u_nxt;
  assign u_nxt = (in_param_u > ONE) ? ONE : in_param_u;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_r <= u_nxt;
      v_r <= ONE - u_nxt;
    end
  end

  // Power ladder: entry k of each row holds p^k once computed
  logic [UW-1:0] up_s [NP+1][MAX_POINTS];
  logic [UW-1:0] vp_s [NP+1][MAX_POINTS];

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      up_s[0][k] = '0;
      vp_s[0][k] = '0;
    end
    up_s[0][0] = ONE;
    vp_s[0][0] = ONE;
    up_s[0][1] = u_r;
    vp_s[0][1] = v_r;
  end

  for (genvar s = 1; s <= NP; s++) begin : g_pow
    bcpe_pow_stage #(
      .UW      (UW),
      .F       (F),
      .NPTS    (MAX_POINTS),
      .POW_IDX (s + 1)
    ) u_pow (
      .clk    (clk),
      .en     (en[s]),
      .up_in  (up_s[s-1]),
      .vp_in  (vp_s[s-1]),
      .up_out (up_s[s]),
      .vp_out (vp_s[s])
    );
  end

  // ---- weights ----
  wgt_en_t       wgt_en;
  logic [WW-1:0] wgt [MAX_POINTS];

  assign wgt_en.prod  = en[NP+1];
  assign wgt_en.scale = en[NP+2];

  bcpe_weight #(
    .UW   (UW),
    .F    (F),
    .NPTS (MAX_POINTS),
    .IW   (IW),
    .WW   (WW)
  ) u_weight (
    .clk (clk),
    .en  (wgt_en),
    .deg (deg),
    .up  (up_s[NP]),
    .vp  (vp_s[NP]),
    .wgt (wgt)
  );

  // ---- weighted sum, round, saturate ----
  acc_en_t acc_en;
  assign acc_en.mul = en[NP+3];
  assign acc_en.sum = en[NP+4];
  assign acc_en.rnd = en[NP+5];

  bcpe_accum #(
    .CW   (CW),
    .F    (F),
    .WW   (WW),
    .NPTS (MAX_POINTS)
  ) u_accum (
    .clk     (clk),
    .en      (acc_en),
    .wgt     (wgt),
    .pt_x    (pt_x),
    .pt_y    (pt_y),
    .curve_x (out_curve_x),
    .curve_y (out_curve_y)
  );

  // ---- checks ----
  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Hold off the sender only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with an empty stage");

  // Words in flight change only by accepted and delivered words
  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ($countones(vld_r) + int'($past(out_acc)) ==
               $past($countones(vld_r)) + int'($past(in_acc))))
    else $error("word lost or repeated in pipeline");

  // Clamped u never exceeds one
  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (u_r <= ONE))
    else $error("u above one after clamp");

endmodule
`default_nettype wire

>>> rtl/core/bcpe_pow_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier power stage
// One pipeline stage of the power ladder: forms p^POW_IDX = round(p^(POW_IDX-1)
// * p) for both u and 1-u and carries the other powers along.
// ----------------------------------------------------------------------------
module bcpe_pow_stage #(
  parameter int UW      = 17,
  parameter int F       = 16,
  parameter int NPTS    = 7,
  parameter int POW_IDX = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [UW-1:0] up_in  [NPTS],
  input  logic [UW-1:0] vp_in  [NPTS],
  output logic [UW-1:0] up_out [NPTS],
  output logic [UW-1:0] vp_out [NPTS]
);
  localparam logic [2*UW-1:0] HALF = (2*UW)'(1) << (F - 1);

  logic [UW-1:0]   up_r   [NPTS];
  logic [UW-1:0]   vp_r   [NPTS];
  logic [UW-1:0]   up_nxt [NPTS];
  logic [UW-1:0]   vp_nxt [NPTS];
  logic [2*UW-1:0] u_prod;
  logic [2*UW-1:0] v_prod;

  always_comb begin
    u_prod = (2*UW)'(up_in[POW_IDX-1]) * (2*UW)'(up_in[1]) + HALF;
    v_prod = (2*UW)'(vp_in[POW_IDX-1]) * (2*UW)'(vp_in[1]) + HALF;
    for (int k = 0; k < NPTS; k++) begin
      up_nxt[k] = up_in[k];
      vp_nxt[k] = vp_in[k];
    end
    up_nxt[POW_IDX] = u_prod[F +: UW];
    vp_nxt[POW_IDX] = v_prod[F +: UW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up_r <= up_nxt;
      vp_r <= vp_nxt;
    end
  end

  assign up_out = up_r;
  assign vp_out = vp_r;

endmodule
`default_nettype wire

>>> rtl/core/bcpe_weight.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier weight unit
// Two stages: round(u^(deg-i) * (1-u)^i) per point, then scale by C(deg,i).
// ----------------------------------------------------------------------------
module bcpe_weight #(
  parameter int UW   = 17,
  parameter int F    = 16,
  parameter int NPTS = 7,
  parameter int IW   = 3,
  parameter int WW   = 22
) (
  input  logic                                clk,
  input  bcpe_pkg::wgt_en_t                   en,
  input  logic [bcpe_pkg::NUM_POINTS_W-1:0]   deg,
  input  logic [UW-1:0]                       up [NPTS],
  input  logic [UW-1:0]                       vp [NPTS],
  output logic [WW-1:0]                       wgt [NPTS]
);
  import bcpe_pkg::*;

  localparam logic [2*UW-1:0] HALF = (2*UW)'(1) << (F - 1);

  logic [UW-1:0] t_r   [NPTS];
  logic [UW-1:0] t_nxt [NPTS];
  logic [WW-1:0] w_r   [NPTS];
  logic [WW-1:0] w_nxt [NPTS];

  always_comb begin
    logic [NUM_POINTS_W-1:0] diff;
    logic [2*UW-1:0]         prod;
    for (int i = 0; i < NPTS; i++) begin
      diff = deg - NUM_POINTS_W'(i);
      prod = (2*UW)'(up[diff[IW-1:0]]) * (2*UW)'(vp[i]) + HALF;
      // points past the degree carry no weight
      t_nxt[i] = (NUM_POINTS_W'(i) <= deg) ? prod[F +: UW] : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NPTS; i++) begin
      w_nxt[i] = WW'(binom_coef(deg, 3'(i))) * WW'(t_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      t_r <= t_nxt;
    end
    if (en.scale) begin
      w_r <= w_nxt;
    end
  end

  assign wgt = w_r;

endmodule
`default_nettype wire

>>> rtl/core/bcpe_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier accumulate unit
// Three stages: point times weight, sum over points, round and saturate.
// ----------------------------------------------------------------------------
module bcpe_accum #(
  parameter int CW   = 16,
  parameter int F    = 16,
  parameter int WW   = 22,
  parameter int NPTS = 7
) (
  input  logic                 clk,
  input  bcpe_pkg::acc_en_t    en,
  input  logic [WW-1:0]        wgt  [NPTS],
  input  logic signed [CW-1:0] pt_x [NPTS],
  input  logic signed [CW-1:0] pt_y [NPTS],
  output logic signed [CW-1:0] curve_x,
  output logic signed [CW-1:0] curve_y
);
  import bcpe_pkg::*;

  localparam int PW = CW + WW + 1;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] HALF_S = SW'(1) << (F - 1);
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [PW-1:0] mx_r   [NPTS];
  logic signed [PW-1:0] my_r   [NPTS];
  logic signed [PW-1:0] mx_nxt [NPTS];
  logic signed [PW-1:0] my_nxt [NPTS];
  logic signed [SW-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [CW-1:0] cx_r, cy_r, cx_nxt, cy_nxt;

  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] q;
    logic signed [CW-1:0] r;
    q = (s + HALF_S) >>> F;
    if (q > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (q < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = q[CW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < NPTS; i++) begin
      mx_nxt[i] = PW'(pt_x[i]) * PW'($signed({1'b0, wgt[i]}));
      my_nxt[i] = PW'(pt_y[i]) * PW'($signed({1'b0, wgt[i]}));
    end
  end

  always_comb begin
    sx_nxt = '0;
    sy_nxt = '0;
    for (int i = 0; i < NPTS; i++) begin
      sx_nxt = sx_nxt + SW'(mx_r[i]);
      sy_nxt = sy_nxt + SW'(my_r[i]);
    end
  end

  assign cx_nxt = rnd_sat(sx_r);
  assign cy_nxt = rnd_sat(sy_r);

  always_ff @(posedge clk) begin
    if (en.mul) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
    end
    if (en.sum) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (en.rnd) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
  end

  assign curve_x = cx_r;
  assign curve_y = cy_r;

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier point evaluator testbench
// Streams parameter words through the evaluator under random idling on both
// channels. Each accepted word is predicted from a shadow copy of the control
// points and the point count. Every returned coordinate pair is compared
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int NPTS     = bcpe_pkg::MAX_POINTS_DEF;
  localparam int CW       = bcpe_pkg::COORD_WIDTH_DEF;
  localparam int FB       = bcpe_pkg::PARAM_FRAC_BITS_DEF;
  localparam longint ONE  = longint'(1) << FB;
  localparam int SETTLE   = NPTS + 12;   // a little past the pipeline depth
  localparam int HOLD_LEN = 80;          // long receiver hold-off, in cycles

  typedef struct {
    logic [FB:0]          u;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } curve_pt_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [bcpe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [2*CW-1:0]                 cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [FB:0]                     in_param_u = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [CW-1:0]            out_curve_x;
  logic signed [CW-1:0]            out_curve_y;

  // Shadow copy of the register file
  logic [2*CW-1:0]                 point_shadow [NPTS];
  logic [2:0]                      count_shadow;

  logic [FB:0]                     u_pending [$];
  curve_pt_t                       curve_expect [$];

  int                              err_count = 0;
  int                              words_in = 0;
  int                              send_idle_pct = 31;
  int                              recv_stall_pct = 31;
  int                              hold_left = 0;
  int                              next_hold = 400;

  bezier_curve_point_eval uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_param_u  (in_param_u),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_curve_x (out_curve_x),
    .out_curve_y (out_curve_y)
  );

  always #2 clk = ~clk;

  // Q1.16 product, rounding half up
  function automatic longint q16_mul(input longint a, input longint b);
    return (a * b + (ONE >> 1)) >> FB;
  endfunction

  // Round half towards plus infinity, then clamp to the coordinate range
  function automatic logic signed [CW-1:0] round_clamp(input longint s);
    longint q;
    q = (s + (ONE >> 1)) >>> FB;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[CW-1:0];
  endfunction

  // Reversed Bernstein sum: point i carries C(n,i) * u^(n-i) * (1-u)^i
  function automatic curve_pt_t eval_curve(input logic [FB:0] u_word);
    curve_pt_t res;
    longint    u, v, cnt, deg, binom, w, sx, sy;
    longint    upow [NPTS];
    longint    vpow [NPTS];
    int        i;
    u = u_word;
    if (u > ONE) u = ONE;
    v = ONE - u;
    cnt = count_shadow;
    if (cnt < 2) cnt = 2;
    if (cnt > NPTS) cnt = NPTS;
    deg = cnt - 1;
    upow[0] = ONE;
    vpow[0] = ONE;
    for (i = 1; i <= deg; i++) begin
      upow[i] = q16_mul(upow[i-1], u);
      vpow[i] = q16_mul(vpow[i-1], v);
    end
    sx = 0;
    sy = 0;
    binom = 1;
    for (i = 0; i <= deg; i++) begin
      w = binom * q16_mul(upow[deg-i], vpow[i]);
      sx += longint'($signed(point_shadow[i][CW-1:0])) * w;
      sy += longint'($signed(point_shadow[i][2*CW-1:CW])) * w;
      binom = binom * (deg - i) / (i + 1);
    end
    res.u = u_word;
    res.x = round_clamp(sx);
    res.y = round_clamp(sy);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Drive one register write; call aligned to a rising edge
  task automatic write_reg(input logic [bcpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [2*CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == bcpe_pkg::REG_NUM_POINTS) count_shadow = val[2:0];
    else point_shadow[idx - bcpe_pkg::REG_POINT_ZERO] = val;
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every queued word has gone in and every result is back,
  // then let the pipeline settle before touching the registers
  task automatic drain();
    while (u_pending.size() != 0 || in_valid || curve_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One coordinate: mostly random, with the extremes mixed in
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'(int'($urandom_range(4095)) - 2048);
      default: return 16'($urandom());
    endcase
  endfunction

  // Parameter word: mostly inside [0, 1.0], some clamped from above
  function automatic logic [FB:0] rand_u();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 6) return 17'(ONE);
    if (pick < 16) return 17'($urandom_range(131071, 65537));
    return 17'($urandom_range(65536));
  endfunction

  task automatic push_u(input logic [FB:0] u);
    u_pending.push_back(u);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next pending word, predict each accepted word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    logic        nxt_valid;
    logic [FB:0] nxt_u;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_param_u <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_u     = in_param_u;
      if (in_valid && in_stall === 1'b0) begin
        curve_expect.push_back(eval_curve(in_param_u));
        words_in  <= words_in + 1;
        nxt_valid = 1'b0;
      end
      // a stalled word stays put; a fresh one goes out unless we idle
      if (!nxt_valid && u_pending.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_u     = u_pending.pop_front();
      end
      in_valid   <= nxt_valid;
      in_param_u <= nxt_u;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random stalls plus the occasional long hold-off, which
  // fills the pipeline and pushes back on the input channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : recv_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (words_in == next_hold) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      next_hold <= next_hold + 700;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result word with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    curve_pt_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (curve_expect.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: x=%0d y=%0d",
                                  out_curve_x, out_curve_y));
      end else begin
        want = curve_expect.pop_front();
        if (out_curve_x !== want.x)
          report_mismatch($sformatf("curve_x u=%0d: got %0d want %0d",
                                    want.u, out_curve_x, want.x));
        if (out_curve_y !== want.y)
          report_mismatch($sformatf("curve_y u=%0d: got %0d want %0d",
                                    want.u, out_curve_y, want.y));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed corners, then randomly configured phases
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int         ph, k, n;
    logic [31:0] d;

    for (k = 0; k < NPTS; k++) begin
      point_shadow[k] = {bcpe_pkg::PT_RST_Y[k], bcpe_pkg::PT_RST_X[k]};
    end
    count_shadow = bcpe_pkg::NUM_POINTS_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset curve: both ends, the midpoint, the step next to each end, two thirds
    // and words above one, which clamp to one
    push_u(17'd0);
    push_u(17'd1);
    push_u(17'd32768);
    push_u(17'd65535);
    push_u(17'(ONE));
    push_u(17'd65537);
    push_u(17'h1FFFF);
    push_u(17'h15555);
    push_u(17'h0AAAA);
    drain();

    // Point count below two acts as two; upper data bits must be ignored
    write_reg(bcpe_pkg::REG_NUM_POINTS, 32'hFFFF_FFF8);
    end_writes();
    push_u(17'd0);
    push_u(17'd16384);
    push_u(17'(ONE));
    drain();
    write_reg(bcpe_pkg::REG_NUM_POINTS, 32'h0000_0001);
    end_writes();
    push_u(17'd49152);
    push_u(17'h1FFFF);
    drain();

    // All points at the positive corner, then the negative one: rounding of
    // the weights can push the sum past the range, so saturation shows
    for (k = 0; k < NPTS; k++) write_reg(3'(k), 32'h7FFF_7FFF);
    write_reg(bcpe_pkg::REG_NUM_POINTS, 32'd7);
    end_writes();
    push_u(17'd0);
    push_u(17'd21845);
    push_u(17'd32768);
    push_u(17'd43690);
    push_u(17'(ONE));
    drain();
    for (k = 0; k < NPTS; k++) write_reg(3'(k), 32'h8000_8000);
    end_writes();
    push_u(17'd1);
    push_u(17'd21845);
    push_u(17'd32767);
    push_u(17'd65535);
    push_u(17'h10001);
    drain();

    // Random phases: new points and count each time, count extremes first
    for (ph = 0; ph < 8; ph++) begin
      for (k = 0; k < NPTS; k++) write_reg(3'(k), {rand_coord(), rand_coord()});
      if (ph == 0) n = 2;
      else if (ph == 1) n = 7;
      else n = $urandom_range(7);
      d = $urandom();
      d[2:0] = 3'(n);
      write_reg(bcpe_pkg::REG_NUM_POINTS, d);
      end_writes();
      // one phase runs flat out on both sides
      send_idle_pct  <= (ph == 3) ? 0 : 31;
      recv_stall_pct <= (ph == 3) ? 0 : 31;
      for (k = 0; k < 200; k++) push_u(rand_u());
      drain();
    end

    if (curve_expect.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", curve_expect.size()));
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
